@@ rtl/core/ir_beacon_search_sequencer_defines.svh @@
// Assertion macros for the IR beacon search sequencer.
`ifndef IR_BEACON_SEARCH_SEQUENCER_DEFINES_SVH
`define IR_BEACON_SEARCH_SEQUENCER_DEFINES_SVH
`ifndef SYNTH
// checked after reset is released
`define IBS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked at every edge, reset included
`define IBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IBS_ASSERT(lbl, clk, rstn, prop, msg)
`define IBS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/core/ibs_pkg.sv @@
// Types and constants shared by the IR beacon search sequencer.
package ibs_pkg;

  localparam int MAG_W     = 16;
  localparam int ELAPSED_W = 12;
  localparam int SPEED_W   = 7;
  localparam int COUNT_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 16;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic [SPEED_W-1:0] SPEED_STRAFE = 7'd90;
  localparam logic [SPEED_W-1:0] SPEED_FAST   = 7'd60;
  localparam logic [SPEED_W-1:0] SPEED_SLOW   = 7'd30;
  localparam logic [SPEED_W-1:0] SPEED_STOP   = 7'd0;

  // reset values of the configuration registers
  localparam logic [MAG_W-1:0]     RST_FOUND_A  = 16'd20000;
  localparam logic [MAG_W-1:0]     RST_FOUND_B  = 16'd7000;
  localparam logic [MAG_W-1:0]     RST_NEAR_A   = 16'd18000;
  localparam logic [MAG_W-1:0]     RST_NEAR_B   = 16'd6000;
  localparam logic [COUNT_W-1:0]   RST_REQ_CNT  = 3'd4;
  localparam logic [ELAPSED_W-1:0] RST_STRAFE   = 12'd2000;
  localparam logic [ELAPSED_W-1:0] RST_BACKWARD = 12'd2000;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_STRAFE   = 3'd1,
    ST_BACK     = 3'd2,
    ST_FWD      = 3'd3,
    ST_FOUND    = 3'd4,
    ST_NOTFOUND = 3'd5
  } state_e;

  typedef enum logic [1:0] {
    DRV_STOP   = 2'd0,
    DRV_STRAFE = 2'd1,
    DRV_BACK   = 2'd2,
    DRV_FWD    = 2'd3
  } drive_e;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_START = 2'd2,
    MODE_STOP  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSOR_SEL = 3'd0,
    CFG_FOUND_A    = 3'd1,
    CFG_FOUND_B    = 3'd2,
    CFG_NEAR_A     = 3'd3,
    CFG_NEAR_B     = 3'd4,
    CFG_REQ_CNT    = 3'd5,
    CFG_STRAFE     = 3'd6,
    CFG_BACKWARD   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic             skip_strafe;
    logic [MAG_W-1:0] mag_first;
    logic [MAG_W-1:0] mag_second;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         search_state;
    logic [1:0]         drive_cmd;
    logic [SPEED_W-1:0] drive_speed;
    logic [MAG_W-1:0]   filtered_mag;
    logic [MAG_W-1:0]   peak_mag;
    logic               done_found;
    logic               done_failed;
  } out_word_t;

  typedef struct packed {
    logic                 sensor_select;
    logic [MAG_W-1:0]     found_threshold_a;
    logic [MAG_W-1:0]     found_threshold_b;
    logic [MAG_W-1:0]     near_threshold_a;
    logic [MAG_W-1:0]     near_threshold_b;
    logic [COUNT_W-1:0]   required_count;
    logic [ELAPSED_W-1:0] strafe_ms;
    logic [ELAPSED_W-1:0] back_search_ms;
  } cfg_t;

endpackage

@@ rtl/core/ibs_cfg.sv @@
// Configuration register file of the beacon search sequencer.
module ibs_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ibs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ibs_pkg::CFG_DW-1:0]    cfg_wdata_i,
  output ibs_pkg::cfg_t                 cfg_o
);
  import ibs_pkg::*;

  cfg_t cfg_q, cfg_d;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SENSOR_SEL: cfg_d.sensor_select     = cfg_wdata_i[0];
        CFG_FOUND_A:    cfg_d.found_threshold_a = cfg_wdata_i[MAG_W-1:0];
        CFG_FOUND_B:    cfg_d.found_threshold_b = cfg_wdata_i[MAG_W-1:0];
        CFG_NEAR_A:     cfg_d.near_threshold_a  = cfg_wdata_i[MAG_W-1:0];
        CFG_NEAR_B:     cfg_d.near_threshold_b  = cfg_wdata_i[MAG_W-1:0];
        CFG_REQ_CNT:    cfg_d.required_count    = cfg_wdata_i[COUNT_W-1:0];
        CFG_STRAFE:     cfg_d.strafe_ms         = cfg_wdata_i[ELAPSED_W-1:0];
        CFG_BACKWARD:   cfg_d.back_search_ms    = cfg_wdata_i[ELAPSED_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_select     <= 1'b0;
      cfg_q.found_threshold_a <= RST_FOUND_A;
      cfg_q.found_threshold_b <= RST_FOUND_B;
      cfg_q.near_threshold_a  <= RST_NEAR_A;
      cfg_q.near_threshold_b  <= RST_NEAR_B;
      cfg_q.required_count    <= RST_REQ_CNT;
      cfg_q.strafe_ms         <= RST_STRAFE;
      cfg_q.back_search_ms    <= RST_BACKWARD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/ibs_filter.sv @@
// Exponential magnitude filter step: f += (raw - f) / 4, floor rounding.
module ibs_filter #(
  parameter int FRACTION_BITS = 8
) (
  input  logic [ibs_pkg::MAG_W+FRACTION_BITS-1:0] filt_i,
  input  logic                                    valid_i,
  input  logic [ibs_pkg::MAG_W-1:0]               raw_i,
  output logic [ibs_pkg::MAG_W+FRACTION_BITS-1:0] filt_o,
  output logic [ibs_pkg::MAG_W-1:0]               int_o
);
  import ibs_pkg::*;

  localparam int FiltW = MAG_W + FRACTION_BITS;

  logic [FiltW-1:0] raw_q8;
  logic [FiltW-1:0] up_diff;
  logic [FiltW:0]   dn_diff;

  assign raw_q8  = {raw_i, {FRACTION_BITS{1'b0}}};
  assign up_diff = raw_q8 - filt_i;
  // rounding toward minus infinity on the way down: add 3 before the shift
  assign dn_diff = {1'b0, filt_i - raw_q8} + (FiltW+1)'(3);

  // first sample loads directly
  always_comb begin
    if (!valid_i) begin
      filt_o = raw_q8;
    end else if (raw_q8 >= filt_i) begin
      filt_o = filt_i + (up_diff >> 2);
    end else begin
      filt_o = filt_i - dn_diff[FiltW+1-1:2];
    end
  end

  assign int_o = filt_o[FiltW-1:FRACTION_BITS];

endmodule

@@ rtl/core/ibs_core.sv @@
// Search state, timers, filter state and per-word result of the sequencer.
module ibs_core #(
  parameter int FORWARD_TIME_MS  = 3000,
  parameter int FRESH_TIMEOUT_MS = 250,
  parameter int FRACTION_BITS    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  ibs_pkg::in_word_t   in_word_i,
  input  ibs_pkg::cfg_t       cfg_i,
  output ibs_pkg::out_word_t  result_o
);
  import ibs_pkg::*;

  localparam int FiltW = MAG_W + FRACTION_BITS;
  localparam int AgeW  = $clog2(FRESH_TIMEOUT_MS + 2);
  localparam logic [AgeW-1:0]      AgeTimeout = AgeW'(FRESH_TIMEOUT_MS);
  localparam logic [AgeW-1:0]      AgeStale   = AgeW'(FRESH_TIMEOUT_MS + 1);
  localparam logic [ELAPSED_W-1:0] FwdTime    = ELAPSED_W'(FORWARD_TIME_MS);

  state_e               state_q, state_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [AgeW-1:0]      age_q, age_d;
  logic [FiltW-1:0]     filt_q, filt_d;
  logic                 fvalid_q, fvalid_d;
  logic [COUNT_W-1:0]   conf_q, conf_d;
  logic [MAG_W-1:0]     peak_q, peak_d;

  logic [FiltW-1:0]     ema_filt;
  logic [MAG_W-1:0]     ema_int;
  logic [MAG_W-1:0]     raw;
  logic [MAG_W-1:0]     found_thr;
  logic [MAG_W-1:0]     near_thr;
  logic [MAG_W-1:0]     out_int;
  drive_e               cmd;
  logic [SPEED_W-1:0]   speed;

  function automatic drive_e entry_cmd(state_e s);
    unique case (s)
      ST_STRAFE: return DRV_STRAFE;
      ST_BACK:   return DRV_BACK;
      ST_FWD:    return DRV_FWD;
      default:   return DRV_STOP;
    endcase
  endfunction

  function automatic logic [SPEED_W-1:0] entry_speed(state_e s);
    unique case (s)
      ST_STRAFE:      return SPEED_STRAFE;
      ST_BACK, ST_FWD: return SPEED_FAST;
      default:        return SPEED_STOP;
    endcase
  endfunction

  assign raw       = cfg_i.sensor_select ? in_word_i.mag_second : in_word_i.mag_first;
  assign found_thr = cfg_i.sensor_select ? cfg_i.found_threshold_b : cfg_i.found_threshold_a;
  assign near_thr  = cfg_i.sensor_select ? cfg_i.near_threshold_b : cfg_i.near_threshold_a;

  ibs_filter #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_filter (
    .filt_i (filt_q),
    .valid_i(fvalid_q),
    .raw_i  (raw),
    .filt_o (ema_filt),
    .int_o  (ema_int)
  );

  // next state and drive for one word
  always_comb begin
    logic               is_frame;
    logic               enter_en;
    state_e             enter_st;
    logic [MAG_W-1:0]   fint;
    logic [COUNT_W-1:0] cnt_next;
    logic               detect;

    state_d   = state_q;
    elapsed_d = elapsed_q;
    age_d     = age_q;
    filt_d    = filt_q;
    fvalid_d  = fvalid_q;
    conf_d    = conf_q;
    peak_d    = peak_q;
    cmd       = DRV_STOP;
    speed     = SPEED_STOP;
    is_frame  = (in_word_i.mode == MODE_FRAME);
    enter_en  = 1'b0;
    enter_st  = ST_IDLE;
    fint      = '0;
    cnt_next  = '0;
    detect    = 1'b0;

    unique case (in_word_i.mode) inside
      MODE_START: begin
        filt_d   = '0;
        fvalid_d = 1'b0;
        peak_d   = '0;
        enter_en = 1'b1;
        enter_st = in_word_i.skip_strafe ? ST_BACK : ST_STRAFE;
      end
      MODE_STOP: begin
        enter_en = 1'b1;
        enter_st = ST_IDLE;
      end
      MODE_TICK, MODE_FRAME: begin
        // timers
        if (is_frame) begin
          age_d = '0;
        end else begin
          if (elapsed_q != ELAPSED_MAX) elapsed_d = elapsed_q + 1'b1;
          if (age_q <= AgeTimeout) age_d = age_q + 1'b1;
        end
        // filter: stale data drops it, a frame feeds it
        if (age_d > AgeTimeout) begin
          filt_d   = '0;
          fvalid_d = 1'b0;
          conf_d   = '0;
        end else if (is_frame) begin
          filt_d   = ema_filt;
          fvalid_d = 1'b1;
          if (ema_int > peak_q) peak_d = ema_int;
        end
        fint     = fvalid_d ? filt_d[FiltW-1:FRACTION_BITS] : '0;
        cnt_next = (fint >= found_thr) ?
                   ((conf_d < cfg_i.required_count) ? conf_d + 1'b1 : conf_d) : '0;
        detect   = fvalid_d && is_frame && (cnt_next >= cfg_i.required_count);
        unique case (state_q)
          ST_STRAFE: begin
            cmd   = DRV_STRAFE;
            speed = SPEED_STRAFE;
            if (elapsed_d >= cfg_i.strafe_ms) begin
              enter_en = 1'b1;
              enter_st = ST_BACK;
            end
          end
          ST_BACK: begin
            cmd   = DRV_BACK;
            speed = (fint >= near_thr) ? SPEED_SLOW : SPEED_FAST;
            if (!fvalid_d) conf_d = '0;
            else if (is_frame) conf_d = cnt_next;
            if (detect) begin
              enter_en = 1'b1;
              enter_st = ST_FOUND;
            end else if (elapsed_d >= cfg_i.back_search_ms) begin
              enter_en = 1'b1;
              enter_st = ST_FWD;
            end
          end
          ST_FWD: begin
            cmd   = DRV_FWD;
            speed = (fint >= near_thr) ? SPEED_SLOW : SPEED_FAST;
            if (!fvalid_d) conf_d = '0;
            else if (is_frame) conf_d = cnt_next;
            if (detect) begin
              enter_en = 1'b1;
              enter_st = ST_FOUND;
            end else if (elapsed_d >= FwdTime) begin
              enter_en = 1'b1;
              enter_st = ST_NOTFOUND;
            end
          end
          default: begin
            cmd   = DRV_STOP;
            speed = SPEED_STOP;
          end
        endcase
      end
    endcase

    // state entry resets the phase timer and the confirm count
    if (enter_en) begin
      state_d   = enter_st;
      elapsed_d = '0;
      conf_d    = '0;
      cmd       = entry_cmd(enter_st);
      speed     = entry_speed(enter_st);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      elapsed_q <= '0;
      age_q     <= AgeStale;
      filt_q    <= '0;
      fvalid_q  <= 1'b0;
      conf_q    <= '0;
      peak_q    <= '0;
    end else if (step_i) begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
      age_q     <= age_d;
      filt_q    <= filt_d;
      fvalid_q  <= fvalid_d;
      conf_q    <= conf_d;
      peak_q    <= peak_d;
    end
  end

  // result word
  assign out_int                = fvalid_d ? filt_d[FiltW-1:FRACTION_BITS] : '0;
  assign result_o.search_state  = state_d;
  assign result_o.drive_cmd     = cmd;
  assign result_o.drive_speed   = speed;
  assign result_o.filtered_mag  = out_int;
  assign result_o.peak_mag      = peak_d;
  assign result_o.done_found    = (state_d == ST_FOUND);
  assign result_o.done_failed   = (state_d == ST_NOTFOUND);

endmodule

@@ rtl/core/ir_beacon_search_sequencer.sv @@
// IR beacon search sequencer: top level with input and result registers.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one word per cycle:
// while in_ready_o is high: a 1 ms tick, a sensor frame with two magnitudes,
// a start (optionally skipping the strafe) or a stop. Each word yields exactly
// one result word on the output channel (out_valid_o/out_ready_i/out_data_o):
// search state, drive command and speed, filtered and peak magnitude, done flags.
// An accepted word goes from the input register into the result register.
// Throughput: one word per cycle while the receiver takes results; the search
// state update is a single pass of compares, one shift-add filter step and
// counter updates between the input and result registers. When the receiver
// stalls, the result register holds its word, the input register takes one
// more word, and in_ready_o drops until the result leaves. Reset clears the
// search state to idle, marks sensor data stale, empties both registers and
// loads the configuration defaults. Configuration words are written by the user
// via cfg_we_i/cfg_idx_i/cfg_wdata_i only while the block is idle (unenforced).
`include "ir_beacon_search_sequencer_defines.svh"
module ir_beacon_search_sequencer #(
  parameter int FORWARD_TIME_MS  = 3000,
  parameter int FRESH_TIMEOUT_MS = 250,
  parameter int FRACTION_BITS    = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ibs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ibs_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ibs_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ibs_pkg::out_word_t            out_data_o
);
  import ibs_pkg::*;

  cfg_t      cfg;
  in_word_t  in_word_q;
  logic      in_valid_q, in_valid_d;
  out_word_t out_word_q, result;
  logic      out_valid_q, out_valid_d;
  logic      advance;
  logic      in_accept;

  ibs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // word moves from the input register into the result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  ibs_core #(
    .FORWARD_TIME_MS (FORWARD_TIME_MS),
    .FRESH_TIMEOUT_MS(FRESH_TIMEOUT_MS),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .in_word_i(in_word_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign in_valid_d  = in_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  // handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) in_word_q <= in_data_i;
    if (advance) out_word_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  // filter output never exceeds the tracked peak
  `IBS_ASSERT(a_filt_le_peak, clk_i, rst_ni, out_valid_q |-> (out_word_q.filtered_mag <= out_word_q.peak_mag), "filtered magnitude above peak")
  // parked states never drive the motors
  `IBS_ASSERT(a_parked_stopped, clk_i, rst_ni, (out_valid_q && (out_word_q.search_state == ST_IDLE || out_word_q.search_state == ST_FOUND || out_word_q.search_state == ST_NOTFOUND)) |-> (out_word_q.drive_cmd == DRV_STOP && out_word_q.drive_speed == SPEED_STOP), "drive active in a parked state")
  // a start clears the peak
  `IBS_ASSERT(a_start_clears_peak, clk_i, rst_ni, (advance && in_word_q.mode == MODE_START) |=> (out_word_q.peak_mag == '0 && out_word_q.filtered_mag == '0), "start did not clear peak")
  // a word waiting in the input register is never dropped
  `IBS_ASSERT_ALWAYS(a_no_drop, clk_i, (rst_ni && in_valid_q && !advance) |=> (!rst_ni || in_valid_q), "input word lost while stalled")

endmodule
